// ===== rtl/sbsh_pkg.sv =====
// Package for the segment/box surface hit block: widths, codes, shared types and helpers.
// Depends on nothing; every other file of the block imports it.
package sbsh_pkg;

  localparam int unsigned NumAxes   = 3;
  localparam int unsigned NumFaces  = 2 * NumAxes;
  localparam int unsigned CoordW    = 32;
  localparam int unsigned DiffW     = CoordW + 1;
  localparam int unsigned ProdW     = 2 * DiffW;
  localparam int unsigned WideW     = 2 * CoordW;
  localparam int unsigned DivSteps  = CoordW;
  localparam int unsigned DivLanes  = NumAxes + 1;
  localparam int unsigned ParamLane = NumAxes;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned ParamFrac = 16;
  localparam int unsigned ParamW    = ParamFrac + 1;
  localparam int unsigned FaceW     = 3;
  localparam int unsigned CfgIdxW   = 3;

  localparam logic [ParamW-1:0] ParamOne = ParamW'(1) << ParamFrac;
  localparam logic [CoordW-1:0] BoxLowReset  = '0;
  localparam logic [CoordW-1:0] BoxHighReset = CoordW'(1) << FracBits;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] REG_X_LOW  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_Y_LOW  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_Z_LOW  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_X_HIGH = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_Y_HIGH = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_Z_HIGH = 3'd5;

  // Face codes: twice the axis, plus one for the upper plane.
  localparam logic [FaceW-1:0] FACE_X_LOW  = 3'd0;
  localparam logic [FaceW-1:0] FACE_X_HIGH = 3'd1;
  localparam logic [FaceW-1:0] FACE_Y_LOW  = 3'd2;
  localparam logic [FaceW-1:0] FACE_Y_HIGH = 3'd3;
  localparam logic [FaceW-1:0] FACE_Z_LOW  = 3'd4;
  localparam logic [FaceW-1:0] FACE_Z_HIGH = 3'd5;

  typedef logic [NumAxes-1:0][CoordW-1:0] vec_t;
  typedef logic [NumAxes-1:0][DiffW-1:0]  dvec_t;

  typedef struct packed {
    logic               start_in;
    logic [NumAxes-1:0] neg;
    vec_t               start;
  } geo_t;

  typedef struct packed {
    logic             hit;
    logic [FaceW-1:0] face;
    geo_t             geo;
  } side_t;

  typedef struct packed {
    logic              hit;
    logic [ParamW-1:0] param;
    vec_t              point;
    logic [FaceW-1:0]  face;
    logic              start_in;
  } result_t;

  function automatic logic [DiffW-1:0] sext(input logic [CoordW-1:0] v);
    return {v[CoordW-1], v};
  endfunction

  function automatic logic [FaceW-1:0] face_code(input int unsigned axis, input logic upper);
    return FaceW'(2 * axis) | {{(FaceW-1){1'b0}}, upper};
  endfunction

  // The j-th of the two axes other than axis a.
  function automatic int unsigned other_axis(input int unsigned a, input int unsigned j);
    return (a + 1 + j >= NumAxes) ? (a + 1 + j - NumAxes) : (a + 1 + j);
  endfunction

endpackage

// ===== rtl/sbsh_face_test.sv =====
// Face candidate test: differences, plane crossings and exact in-face checks, four stages.
// Depends on sbsh_pkg.
module sbsh_face_test import sbsh_pkg::*; (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  vec_t                              start_i,
  input  vec_t                              stop_i,
  input  vec_t                              box_lo_i,
  input  vec_t                              box_hi_i,
  output logic                              valid_o,
  output logic [NumFaces-1:0]               ok_o,
  output logic [NumFaces-1:0][CoordW-1:0]   num_o,
  output vec_t                              den_o,
  output geo_t                              geo_o
);

  // Stage A: differences.
  logic  a_v_q;
  vec_t  a_start_q;
  dvec_t a_q_q, a_nl_q, a_nh_q;

  // Stage B: sign folding and the range test on each crossing.
  logic                            b_v_q;
  logic [NumFaces-1:0]             b_cand_q, b_cand_d;
  logic [NumFaces-1:0][CoordW-1:0] b_num_q, b_num_d;
  vec_t                            b_den_q, b_den_d;
  dvec_t                           b_q_q, b_nl_q, b_nh_q;
  geo_t                            b_geo_q, b_geo_d;

  // Stage C: cross products.
  logic                            c_v_q;
  logic [NumFaces-1:0]             c_cand_q;
  logic [NumFaces-1:0][CoordW-1:0] c_num_q;
  vec_t                            c_den_q;
  geo_t                            c_geo_q;
  logic [ProdW-1:0]                c_plo_q [NumAxes][2];
  logic [ProdW-1:0]                c_phi_q [NumAxes][2];
  logic [ProdW-1:0]                c_pn_q  [NumFaces][2];

  // Stage D: compares.
  logic                            d_v_q;
  logic [NumFaces-1:0]             d_ok_q, d_ok_d;
  logic [NumFaces-1:0][CoordW-1:0] d_num_q;
  vec_t                            d_den_q;
  geo_t                            d_geo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
    end else if (en_i) begin
      a_v_q <= valid_i;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
      d_v_q <= c_v_q;
    end
  end

  always_comb begin
    logic [DiffW-1:0] qm;
    logic [DiffW-1:0] n;
    logic [DiffW-1:0] np;
    b_geo_d.start    = a_start_q;
    b_geo_d.start_in = 1'b1;
    b_geo_d.neg      = '0;
    b_cand_d         = '0;
    b_num_d          = '0;
    b_den_d          = '0;
    for (int unsigned a = 0; a < NumAxes; a++) begin
      b_geo_d.neg[a] = a_q_q[a][DiffW-1];
      qm = a_q_q[a][DiffW-1] ? (-a_q_q[a]) : a_q_q[a];
      b_den_d[a] = qm[CoordW-1:0];
      if (!($signed(a_nl_q[a]) < 0 && $signed(a_nh_q[a]) > 0)) begin
        b_geo_d.start_in = 1'b0;
      end
      for (int unsigned k = 0; k < 2; k++) begin
        n  = (k != 0) ? a_nh_q[a] : a_nl_q[a];
        np = a_q_q[a][DiffW-1] ? (-n) : n;
        b_cand_d[2*a+k] = (a_q_q[a] != '0) && !np[DiffW-1] && (np != '0) && (np <= qm);
        b_num_d[2*a+k]  = np[CoordW-1:0];
      end
    end
  end

  always_comb begin
    for (int unsigned a = 0; a < NumAxes; a++) begin
      for (int unsigned k = 0; k < 2; k++) begin
        d_ok_d[2*a+k] = c_cand_q[2*a+k];
        for (int unsigned j = 0; j < 2; j++) begin
          if ($signed(c_plo_q[a][j]) > $signed(c_pn_q[2*a+k][j]) ||
              $signed(c_pn_q[2*a+k][j]) > $signed(c_phi_q[a][j])) begin
            d_ok_d[2*a+k] = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_start_q <= start_i;
      for (int unsigned a = 0; a < NumAxes; a++) begin
        a_q_q[a]  <= sext(stop_i[a]) - sext(start_i[a]);
        a_nl_q[a] <= sext(box_lo_i[a]) - sext(start_i[a]);
        a_nh_q[a] <= sext(box_hi_i[a]) - sext(start_i[a]);
      end

      b_cand_q <= b_cand_d;
      b_num_q  <= b_num_d;
      b_den_q  <= b_den_d;
      b_q_q    <= a_q_q;
      b_nl_q   <= a_nl_q;
      b_nh_q   <= a_nh_q;
      b_geo_q  <= b_geo_d;

      c_cand_q <= b_cand_q;
      c_num_q  <= b_num_q;
      c_den_q  <= b_den_q;
      c_geo_q  <= b_geo_q;
      for (int unsigned a = 0; a < NumAxes; a++) begin
        for (int unsigned j = 0; j < 2; j++) begin
          c_plo_q[a][j] <= $signed(b_nl_q[other_axis(a, j)]) * $signed({1'b0, b_den_q[a]});
          c_phi_q[a][j] <= $signed(b_nh_q[other_axis(a, j)]) * $signed({1'b0, b_den_q[a]});
          for (int unsigned k = 0; k < 2; k++) begin
            c_pn_q[2*a+k][j] <= $signed({1'b0, b_num_q[2*a+k]}) *
                                $signed(b_q_q[other_axis(a, j)]);
          end
        end
      end

      d_ok_q  <= d_ok_d;
      d_num_q <= c_num_q;
      d_den_q <= c_den_q;
      d_geo_q <= c_geo_q;
    end
  end

  assign valid_o = d_v_q;
  assign ok_o    = d_ok_q;
  assign num_o   = d_num_q;
  assign den_o   = d_den_q;
  assign geo_o   = d_geo_q;

endmodule

// ===== rtl/sbsh_select.sv =====
// Picks the earliest valid face crossing by exact fraction compares, then forms the dividends.
// Depends on sbsh_pkg.
module sbsh_select import sbsh_pkg::*; (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic [NumFaces-1:0]               ok_i,
  input  logic [NumFaces-1:0][CoordW-1:0]   num_i,
  input  vec_t                              den_i,
  input  geo_t                              geo_i,
  output logic                              valid_o,
  output logic [DivLanes-1:0][WideW-1:0]    dividend_o,
  output logic [CoordW-1:0]                 divisor_o,
  output side_t                             side_o
);

  // Stage E: best face of each axis (same denominator, so numerators compare).
  logic               e_v_q;
  logic [NumAxes-1:0] e_ok_q;
  logic [NumAxes-1:0] e_k_q;
  vec_t               e_n_q;
  vec_t               e_den_q;
  geo_t               e_geo_q;

  // Stage F: cross products of x against y.
  logic               f_v_q;
  logic [NumAxes-1:0] f_ok_q;
  logic [NumAxes-1:0] f_k_q;
  vec_t               f_n_q;
  vec_t               f_den_q;
  geo_t               f_geo_q;
  logic [WideW-1:0]   f_m0_q, f_m1_q;

  // Stage G: winner of x and y.
  logic               g_v_q;
  logic               g_ok_q;
  logic [FaceW-1:0]   g_face_q;
  logic [CoordW-1:0]  g_n_q, g_d_q;
  logic               g_ok2_q, g_k2_q;
  logic [CoordW-1:0]  g_n2_q;
  vec_t               g_den_q;
  geo_t               g_geo_q;

  // Stage H: cross products of that winner against z.
  logic               h_v_q;
  logic               h_ok_q;
  logic [FaceW-1:0]   h_face_q;
  logic [CoordW-1:0]  h_n_q, h_d_q;
  logic               h_ok2_q, h_k2_q;
  logic [CoordW-1:0]  h_n2_q;
  vec_t               h_den_q;
  geo_t               h_geo_q;
  logic [WideW-1:0]   h_m0_q, h_m1_q;

  // Stage I: overall winner.
  logic               i_v_q;
  logic               i_hit_q;
  logic [FaceW-1:0]   i_face_q;
  logic [CoordW-1:0]  i_n_q, i_d_q;
  vec_t               i_den_q;
  geo_t               i_geo_q;

  // Stage J: dividends.
  logic                           j_v_q;
  logic [DivLanes-1:0][WideW-1:0] j_div_q;
  logic [CoordW-1:0]              j_d_q;
  side_t                          j_side_q;

  logic pick_g, pick_i;

  // A later candidate wins over an invalid one, else only if strictly earlier on the segment.
  assign pick_g = !f_ok_q[0] || (f_ok_q[1] && (f_m1_q < f_m0_q));
  assign pick_i = !h_ok_q || (h_ok2_q && (h_m1_q < h_m0_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_v_q <= 1'b0;
      f_v_q <= 1'b0;
      g_v_q <= 1'b0;
      h_v_q <= 1'b0;
      i_v_q <= 1'b0;
      j_v_q <= 1'b0;
    end else if (en_i) begin
      e_v_q <= valid_i;
      f_v_q <= e_v_q;
      g_v_q <= f_v_q;
      h_v_q <= g_v_q;
      i_v_q <= h_v_q;
      j_v_q <= i_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int unsigned a = 0; a < NumAxes; a++) begin
        e_ok_q[a] <= ok_i[2*a] || ok_i[2*a+1];
        if (!ok_i[2*a] || (ok_i[2*a+1] && (num_i[2*a+1] < num_i[2*a]))) begin
          e_k_q[a] <= 1'b1;
          e_n_q[a] <= num_i[2*a+1];
        end else begin
          e_k_q[a] <= 1'b0;
          e_n_q[a] <= num_i[2*a];
        end
      end
      e_den_q <= den_i;
      e_geo_q <= geo_i;

      f_ok_q  <= e_ok_q;
      f_k_q   <= e_k_q;
      f_n_q   <= e_n_q;
      f_den_q <= e_den_q;
      f_geo_q <= e_geo_q;
      f_m0_q  <= e_n_q[0] * e_den_q[1];
      f_m1_q  <= e_n_q[1] * e_den_q[0];

      g_ok_q   <= f_ok_q[0] || f_ok_q[1];
      g_face_q <= pick_g ? face_code(1, f_k_q[1]) : face_code(0, f_k_q[0]);
      g_n_q    <= pick_g ? f_n_q[1] : f_n_q[0];
      g_d_q    <= pick_g ? f_den_q[1] : f_den_q[0];
      g_ok2_q  <= f_ok_q[2];
      g_k2_q   <= f_k_q[2];
      g_n2_q   <= f_n_q[2];
      g_den_q  <= f_den_q;
      g_geo_q  <= f_geo_q;

      h_ok_q   <= g_ok_q;
      h_face_q <= g_face_q;
      h_n_q    <= g_n_q;
      h_d_q    <= g_d_q;
      h_ok2_q  <= g_ok2_q;
      h_k2_q   <= g_k2_q;
      h_n2_q   <= g_n2_q;
      h_den_q  <= g_den_q;
      h_geo_q  <= g_geo_q;
      h_m0_q   <= g_n_q * g_den_q[2];
      h_m1_q   <= g_n2_q * g_d_q;

      i_hit_q  <= h_ok_q || h_ok2_q;
      i_face_q <= pick_i ? face_code(2, h_k2_q) : h_face_q;
      i_n_q    <= pick_i ? h_n2_q : h_n_q;
      i_d_q    <= pick_i ? h_den_q[2] : h_d_q;
      i_den_q  <= h_den_q;
      i_geo_q  <= h_geo_q;

      for (int unsigned b = 0; b < NumAxes; b++) begin
        j_div_q[b] <= i_n_q * i_den_q[b];
      end
      j_div_q[ParamLane] <= WideW'({i_n_q, ParamFrac'(0)});
      j_d_q              <= i_d_q;
      j_side_q.hit       <= i_hit_q;
      j_side_q.face      <= i_face_q;
      j_side_q.geo       <= i_geo_q;
    end
  end

  assign valid_o    = j_v_q;
  assign dividend_o = j_div_q;
  assign divisor_o  = j_d_q;
  assign side_o     = j_side_q;

endmodule

// ===== rtl/sbsh_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, for the point and parameter lanes.
// Depends on sbsh_pkg. Each quotient fits in CoordW bits, so the upper dividend half starts as
// the partial remainder.
module sbsh_div import sbsh_pkg::*; (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic [DivLanes-1:0][WideW-1:0]    dividend_i,
  input  logic [CoordW-1:0]                 divisor_i,
  input  side_t                             side_i,
  output logic                              valid_o,
  output logic [DivLanes-1:0][CoordW-1:0]   quo_o,
  output logic [DivLanes-1:0][CoordW-1:0]   rem_o,
  output logic [CoordW-1:0]                 divisor_o,
  output side_t                             side_o
);

  logic [DivSteps-1:0]                  v_q;
  logic [DivLanes-1:0][CoordW-1:0]      rem_q [DivSteps];
  logic [DivLanes-1:0][CoordW-1:0]      lq_q  [DivSteps];
  logic [CoordW-1:0]                    d_q   [DivSteps];
  side_t                                side_q [DivSteps];

  for (genvar i = 0; i < DivSteps; i++) begin : g_step
    logic                            v_in;
    logic [DivLanes-1:0][CoordW-1:0] rem_in, lq_in, rem_d, lq_d;
    logic [CoordW-1:0]               d_in;
    side_t                           side_in;

    if (i == 0) begin : g_first
      assign v_in    = valid_i;
      assign d_in    = divisor_i;
      assign side_in = side_i;
      always_comb begin
        for (int unsigned l = 0; l < DivLanes; l++) begin
          rem_in[l] = dividend_i[l][WideW-1:CoordW];
          lq_in[l]  = dividend_i[l][CoordW-1:0];
        end
      end
    end else begin : g_next
      assign v_in    = v_q[i-1];
      assign d_in    = d_q[i-1];
      assign side_in = side_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign lq_in   = lq_q[i-1];
    end

    always_comb begin
      logic [CoordW:0] t;
      for (int unsigned l = 0; l < DivLanes; l++) begin
        t = {rem_in[l], lq_in[l][CoordW-1]};
        if (t >= {1'b0, d_in}) begin
          rem_d[l] = CoordW'(t - {1'b0, d_in});
          lq_d[l]  = {lq_in[l][CoordW-2:0], 1'b1};
        end else begin
          rem_d[l] = t[CoordW-1:0];
          lq_d[l]  = {lq_in[l][CoordW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= rem_d;
        lq_q[i]   <= lq_d;
        d_q[i]    <= d_in;
        side_q[i] <= side_in;
      end
    end
  end

  assign valid_o   = v_q[DivSteps-1];
  assign quo_o     = lq_q[DivSteps-1];
  assign rem_o     = rem_q[DivSteps-1];
  assign divisor_o = d_q[DivSteps-1];
  assign side_o    = side_q[DivSteps-1];

endmodule

// ===== rtl/segment_box_surface_hit_top.sv =====
// Top level of the segment/box surface hit block: box registers, pipeline, rounding, output.
// Depends on sbsh_pkg, sbsh_face_test, sbsh_select and sbsh_div.
//
//   Channel  Direction  Handshake                  Word
//   in       input      in_valid_i / in_stall_o    start_x..z, stop_x..z
//   out      output     out_valid_o / out_stall_i  hit, hit_param, hit_x..z, hit_face,
//                                                  start_inside
//   cfg      input      cfg_we_i                   cfg_index_i, cfg_data_i
//
// One word is accepted per cycle unless the input is stalled. Each word passes four stages
// of face tests, six of selection, the 32-stage divider with one quotient bit per stage, one
// for rounding and the output register. Reset clears every valid bit and loads the unit box
// (low bounds 0.0, high bounds 1.0). The whole pipeline advances together. Behind the output
// register sits one skid register, so a stalled output still lets the pipeline advance until
// a word lands in the skid register; the input is stalled only while the skid register is
// occupied, and nothing is dropped or repeated.
module segment_box_surface_hit_top import sbsh_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [CoordW-1:0]   start_x_i,
  input  logic signed [CoordW-1:0]   start_y_i,
  input  logic signed [CoordW-1:0]   start_z_i,
  input  logic signed [CoordW-1:0]   stop_x_i,
  input  logic signed [CoordW-1:0]   stop_y_i,
  input  logic signed [CoordW-1:0]   stop_z_i,
  input  logic                       cfg_we_i,
  input  logic [CfgIdxW-1:0]         cfg_index_i,
  input  logic [CoordW-1:0]          cfg_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       hit_o,
  output logic [ParamW-1:0]          hit_param_o,
  output logic signed [CoordW-1:0]   hit_x_o,
  output logic signed [CoordW-1:0]   hit_y_o,
  output logic signed [CoordW-1:0]   hit_z_o,
  output logic [FaceW-1:0]           hit_face_o,
  output logic                       start_inside_o
);

  // Box bounds. The user must change them only while the block is idle; nothing enforces it.
  vec_t box_lo_q, box_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned a = 0; a < NumAxes; a++) begin
        box_lo_q[a] <= BoxLowReset;
        box_hi_q[a] <= BoxHighReset;
      end
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_X_LOW:  box_lo_q[0] <= cfg_data_i;
        REG_Y_LOW:  box_lo_q[1] <= cfg_data_i;
        REG_Z_LOW:  box_lo_q[2] <= cfg_data_i;
        REG_X_HIGH: box_hi_q[0] <= cfg_data_i;
        REG_Y_HIGH: box_hi_q[1] <= cfg_data_i;
        REG_Z_HIGH: box_hi_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline advance: held only while the skid register is full.
  logic en, accept;
  logic skid_valid_q, out_valid_q;

  assign en         = !skid_valid_q;
  assign in_stall_o = !en;
  assign accept     = in_valid_i && en;

  vec_t start_vec, stop_vec;
  assign start_vec = {start_z_i, start_y_i, start_x_i};
  assign stop_vec  = {stop_z_i, stop_y_i, stop_x_i};

  logic                            ft_valid;
  logic [NumFaces-1:0]             ft_ok;
  logic [NumFaces-1:0][CoordW-1:0] ft_num;
  vec_t                            ft_den;
  geo_t                            ft_geo;

  sbsh_face_test u_face_test (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (accept),
    .start_i  (start_vec),
    .stop_i   (stop_vec),
    .box_lo_i (box_lo_q),
    .box_hi_i (box_hi_q),
    .valid_o  (ft_valid),
    .ok_o     (ft_ok),
    .num_o    (ft_num),
    .den_o    (ft_den),
    .geo_o    (ft_geo)
  );

  logic                           sel_valid;
  logic [DivLanes-1:0][WideW-1:0] sel_dividend;
  logic [CoordW-1:0]              sel_divisor;
  side_t                          sel_side;

  sbsh_select u_select (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (ft_valid),
    .ok_i       (ft_ok),
    .num_i      (ft_num),
    .den_i      (ft_den),
    .geo_i      (ft_geo),
    .valid_o    (sel_valid),
    .dividend_o (sel_dividend),
    .divisor_o  (sel_divisor),
    .side_o     (sel_side)
  );

  logic                            div_valid;
  logic [DivLanes-1:0][CoordW-1:0] div_quo, div_rem;
  logic [CoordW-1:0]               div_divisor;
  side_t                           div_side;

  sbsh_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (sel_valid),
    .dividend_i (sel_dividend),
    .divisor_i  (sel_divisor),
    .side_i     (sel_side),
    .valid_o    (div_valid),
    .quo_o      (div_quo),
    .rem_o      (div_rem),
    .divisor_o  (div_divisor),
    .side_o     (div_side)
  );

  // Rounding stage: the quotient goes up by one when twice the remainder reaches the divisor,
  // which is round to nearest with halves away from the start point.
  logic                            k_v_q;
  logic [DivLanes-1:0][CoordW-1:0] k_off_q, k_off_d;
  side_t                           k_side_q;

  always_comb begin
    for (int unsigned l = 0; l < DivLanes; l++) begin
      k_off_d[l] = div_quo[l] +
                   CoordW'({div_rem[l], 1'b0} >= {1'b0, div_divisor});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_v_q <= 1'b0;
    end else if (en) begin
      k_v_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      k_off_q  <= k_off_d;
      k_side_q <= div_side;
    end
  end

  // Result assembly. On the face's own axis the point is that plane exactly.
  result_t res_d;

  always_comb begin
    res_d = '0;
    if (k_side_q.hit) begin
      res_d.hit      = 1'b1;
      res_d.param    = k_off_q[ParamLane][ParamW-1:0];
      res_d.face     = k_side_q.face;
      res_d.start_in = k_side_q.geo.start_in;
      for (int unsigned b = 0; b < NumAxes; b++) begin
        if (k_side_q.face[FaceW-1:1] == 2'(b)) begin
          res_d.point[b] = k_side_q.face[0] ? box_hi_q[b] : box_lo_q[b];
        end else if (k_side_q.geo.neg[b]) begin
          res_d.point[b] = k_side_q.geo.start[b] - k_off_q[b];
        end else begin
          res_d.point[b] = k_side_q.geo.start[b] + k_off_q[b];
        end
      end
    end
  end

  // Output register with one skid register behind it.
  result_t out_q, skid_q;
  logic    wr, fire_out;

  assign wr       = en && k_v_q;
  assign fire_out = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (fire_out) begin
        skid_valid_q <= 1'b0;
      end
    end else if (wr) begin
      if (out_valid_q && !fire_out) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (fire_out) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (fire_out) begin
        out_q <= skid_q;
      end
    end else if (wr) begin
      if (out_valid_q && !fire_out) begin
        skid_q <= res_d;
      end else begin
        out_q <= res_d;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hit_o          = out_q.hit;
  assign hit_param_o    = out_q.param;
  assign hit_x_o        = out_q.point[0];
  assign hit_y_o        = out_q.point[1];
  assign hit_z_o        = out_q.point[2];
  assign hit_face_o     = out_q.face;
  assign start_inside_o = out_q.start_in;

  // The skid register is only ever occupied behind a waiting output word.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a word while the output register is empty");

  // The skid register fills only when the output word was held back.
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && out_stall_i))
    else $error("skid register filled without an output stall");

  // A miss carries all-zero fields.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !hit_o) |-> (hit_param_o == '0) && (hit_face_o == FACE_X_LOW) &&
      !start_inside_o && (hit_x_o == '0) && (hit_y_o == '0) && (hit_z_o == '0))
    else $error("miss word carries non-zero fields");

  // A hit names a real face and a parameter no larger than one.
  a_hit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && hit_o) |-> (hit_face_o <= FACE_Z_HIGH) && (hit_param_o <= ParamOne))
    else $error("hit word has a face code or parameter out of range");

endmodule
